// ===== rtl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: shared definitions for the segment / strip crossing block
// Widths, register indexes, reset values and the types passed between the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int COEF_FRAC_BITS  = 14;

   localparam int COORD_W = 32;
   localparam int COEF_W  = 16;
   localparam int ROW_W   = 3 * COEF_W;
   localparam int LOC_W   = 32;
   localparam int OFS_W   = 32;
   localparam int HW_W    = 31;

   localparam int PROD_W = COEF_W + COORD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SUM_W  = ACC_W + 1;
   localparam int DIFF_W = LOC_W + 1;
   localparam int XB_W   = LOC_W + 1;
   localparam int T_W    = COORD_FRAC_BITS + 1;
   localparam int MP_W   = T_W + 1 + DIFF_W;
   localparam int XC_W   = DIFF_W + 2;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int FRONT_STAGES = 4;
   localparam int BACK_STAGES  = 3;
   localparam int RSP_LATENCY  = FRONT_STAGES + 1 + T_W + BACK_STAGES;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] REG_X_COEFS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_COEFS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Z_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WIDTH = 3'd4;

   localparam int COEF_ONE = 1 << COEF_FRAC_BITS;

   localparam logic [ROW_W-1:0] X_COEFS_RST = ROW_W'(COEF_ONE);
   localparam logic [ROW_W-1:0] Z_COEFS_RST = ROW_W'(COEF_ONE) << (2 * COEF_W);
   localparam logic [HW_W-1:0]  HW_RST      = HW_W'(1 << COORD_FRAC_BITS);

   localparam logic signed [LOC_W-1:0] LOC_MAX = {1'b0, {(LOC_W-1){1'b1}}};
   localparam logic signed [LOC_W-1:0] LOC_MIN = {1'b1, {(LOC_W-1){1'b0}}};

   typedef struct packed {
      logic [ROW_W-1:0] x_row_coefs;
      logic [OFS_W-1:0] x_row_offset;
      logic [ROW_W-1:0] z_row_coefs;
      logic [OFS_W-1:0] z_row_offset;
      logic [HW_W-1:0]  half_width;
   } ssc_cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } ssc_point_type;

   // classified segment, as handed from the front end to the back end
   typedef struct packed {
      logic                     in_range;
      logic                     beg_inside;
      logic [DIFF_W-1:0]        num;
      logic [DIFF_W-1:0]        den;
      logic signed [LOC_W-1:0]  xb;
      logic signed [DIFF_W-1:0] dx;
      logic signed [LOC_W-1:0]  zb;
   } ssc_item_type;

   typedef struct packed {
      logic                    hit;
      logic                    dist_valid;
      logic signed [LOC_W-1:0] distance;
   } ssc_result_type;

endpackage

`default_nettype wire

// ===== rtl/segment_strip_crossing.sv =====
// ----------------------------------------------------------------------------
// segment_strip_crossing: segment against strip crossing test
// A transaction passes the 4 front stages, the queue, the 17 one-bit-per-stage
//   divider stages and the 3 back stages before its result is strobed.
// Throughput: one transaction per cycle while busy is low, set by the divider.
// busy is high during reset and while the front waits on a full queue.
// Reset clears the pipeline and queue and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_strip_crossing (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ssc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ssc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ssc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_beg_x,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_beg_y,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_beg_z,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_end_y,
   input  logic signed [ssc_pkg::COORD_W-1:0] req_end_z,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic                               rsp_dist_valid,
   output logic signed [ssc_pkg::LOC_W-1:0]   rsp_distance
);
   import ssc_pkg::*;

   ssc_cfg_type          cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;
   ssc_point_type        beg_pt, end_pt;
   logic                 q_full, q_push, q_valid;
   ssc_item_type         q_push_item, q_item;
   ssc_result_type       result;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_X_COEFS:    cfg_in.x_row_coefs  = pwdata[ROW_W-1:0];
            REG_X_OFFSET:   cfg_in.x_row_offset = pwdata[OFS_W-1:0];
            REG_Z_COEFS:    cfg_in.z_row_coefs  = pwdata[ROW_W-1:0];
            REG_Z_OFFSET:   cfg_in.z_row_offset = pwdata[OFS_W-1:0];
            REG_HALF_WIDTH: cfg_in.half_width   = pwdata[HW_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_X_COEFS:    prdata = CSR_DATA_W'(cfg_ff.x_row_coefs);
         REG_X_OFFSET:   prdata = CSR_DATA_W'(cfg_ff.x_row_offset);
         REG_Z_COEFS:    prdata = CSR_DATA_W'(cfg_ff.z_row_coefs);
         REG_Z_OFFSET:   prdata = CSR_DATA_W'(cfg_ff.z_row_offset);
         REG_HALF_WIDTH: prdata = CSR_DATA_W'(cfg_ff.half_width);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_row_coefs  <= X_COEFS_RST;
         cfg_ff.x_row_offset <= '0;
         cfg_ff.z_row_coefs  <= Z_COEFS_RST;
         cfg_ff.z_row_offset <= '0;
         cfg_ff.half_width   <= HW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign beg_pt = '{x: req_beg_x, y: req_beg_y, z: req_beg_z};
   assign end_pt = '{x: req_end_x, y: req_end_y, z: req_end_z};

   ssc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (start),
      .busy      (busy),
      .beg_pt    (beg_pt),
      .end_pt    (end_pt),
      .q_full    (q_full),
      .push      (q_push),
      .push_item (q_push_item)
   );

   ssc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   ssc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (q_valid),
      .in_item    (q_item),
      .out_strobe (rsp_strobe),
      .out_result (result)
   );

   assign rsp_hit        = result.hit;
   assign rsp_dist_valid = result.dist_valid;
   assign rsp_distance   = result.distance;

endmodule

`default_nettype wire

// ===== rtl/ssc_front.sv =====
// ----------------------------------------------------------------------------
// ssc_front: transform and classify
// Maps both points into the strip frame, then forms the crossing numerator
// and denominator and the range and begin-point tests.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  ssc_pkg::ssc_cfg_type  cfg,
   input  logic                  start,
   output logic                  busy,
   input  ssc_pkg::ssc_point_type beg_pt,
   input  ssc_pkg::ssc_point_type end_pt,
   input  logic                  q_full,
   output logic                  push,
   output ssc_pkg::ssc_item_type push_item
);
   import ssc_pkg::*;

   // point order: begin x, begin z, end x, end z
   logic signed [PROD_W-1:0] prod_ff [4][3];
   logic signed [PROD_W-1:0] prod_in [4][3];
   logic signed [ACC_W-1:0]  acc_ff [4];
   logic signed [ACC_W-1:0]  acc_in [4];
   logic signed [LOC_W-1:0]  loc_ff [4];
   logic signed [LOC_W-1:0]  loc_in [4];
   ssc_item_type             item_ff, item_in;
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic                     adv, accept;

   function automatic logic signed [LOC_W-1:0] sat_loc(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi, lo;
      hi = SUM_W'(LOC_MAX);
      lo = SUM_W'(LOC_MIN);
      if (v > hi) sat_loc = LOC_MAX;
      else if (v < lo) sat_loc = LOC_MIN;
      else sat_loc = LOC_W'(v);
   endfunction

   assign adv    = !(v4_ff && q_full);
   assign busy   = reset || !adv;
   assign accept = start && !busy;
   assign push   = v4_ff && adv;
   assign push_item = item_ff;

   always_comb begin
      ssc_point_type           pt;
      logic [ROW_W-1:0]        row;
      logic signed [COEF_W-1:0] cf;
      logic signed [COORD_W-1:0] cd;
      for (int k = 0; k < 4; k++) begin
         pt  = (k < 2) ? beg_pt : end_pt;
         row = (k[0] == 1'b0) ? cfg.x_row_coefs : cfg.z_row_coefs;
         for (int j = 0; j < 3; j++) begin
            cf = signed'(row[j*COEF_W +: COEF_W]);
            cd = (j == 0) ? pt.x : ((j == 1) ? pt.y : pt.z);
            prod_in[k][j] = cf * cd;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         acc_in[k] = ACC_W'(prod_ff[k][0]) + ACC_W'(prod_ff[k][1]) + ACC_W'(prod_ff[k][2]);
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] sh;
      logic signed [SUM_W-1:0] sum;
      logic signed [OFS_W-1:0] ofs;
      for (int k = 0; k < 4; k++) begin
         ofs = (k[0] == 1'b0) ? signed'(cfg.x_row_offset) : signed'(cfg.z_row_offset);
         // arithmetic shift rounds toward minus infinity
         sh  = acc_ff[k] >>> COEF_FRAC_BITS;
         sum = SUM_W'(sh) + SUM_W'(ofs);
         loc_in[k] = sat_loc(sum);
      end
   end

   always_comb begin
      logic signed [DIFF_W-1:0] dz;
      logic signed [DIFF_W-1:0] nums;
      logic signed [XB_W-1:0]   xbw;
      logic signed [XB_W-1:0]   axb;
      logic                     neg;
      dz   = DIFF_W'(loc_ff[3]) - DIFF_W'(loc_ff[1]);
      neg  = dz[DIFF_W-1];
      // flip both signs so the denominator is positive
      nums = neg ? DIFF_W'(loc_ff[1]) : -DIFF_W'(loc_ff[1]);
      xbw  = XB_W'(loc_ff[0]);
      axb  = xbw[XB_W-1] ? -xbw : xbw;
      item_in.num = unsigned'(nums);
      item_in.den = neg ? unsigned'(-dz) : unsigned'(dz);
      item_in.in_range = (dz != '0) && !nums[DIFF_W-1]
                         && (unsigned'(nums) <= item_in.den);
      item_in.beg_inside = unsigned'(axb) < XB_W'(cfg.half_width);
      item_in.xb = loc_ff[0];
      item_in.zb = loc_ff[1];
      item_in.dx = DIFF_W'(loc_ff[2]) - DIFF_W'(loc_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         loc_ff  <= loc_in;
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ssc_queue.sv =====
// ----------------------------------------------------------------------------
// ssc_queue: classified segment queue
// Short first-in first-out buffer between the front end and the back end.
// The head is handed on in every cycle in which the queue holds an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssc_pkg::ssc_item_type push_item,
   output logic                  full,
   output logic                  pop_valid,
   output ssc_pkg::ssc_item_type pop_item
);
   import ssc_pkg::*;

   ssc_item_type      entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid;
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = QCNT_W'(count_ff + 1'b1);
         2'b01:   count_in = QCNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ssc_div.sv =====
// ----------------------------------------------------------------------------
// ssc_div: pipelined crossing parameter divider
// Restoring division of num * 2^COORD_FRAC_BITS by den for num <= den,
// one quotient bit per stage, with the segment carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ssc_pkg::ssc_item_type  in_item,
   output logic                   out_valid,
   output logic [ssc_pkg::T_W-1:0] out_t,
   output ssc_pkg::ssc_item_type  out_item
);
   import ssc_pkg::*;

   logic              v_ff [T_W];
   logic [DIFF_W-1:0] r_ff [T_W];
   logic [DIFF_W-1:0] r_in [T_W];
   logic [T_W-1:0]    q_ff [T_W];
   logic [T_W-1:0]    q_in [T_W];
   ssc_item_type      item_ff [T_W];

   always_comb begin
      logic            ge;
      logic [DIFF_W:0] r2;
      // top quotient bit: set when num >= den, so for num <= den only when they are equal
      ge      = in_item.num >= in_item.den;
      r_in[0] = ge ? DIFF_W'(in_item.num - in_item.den) : in_item.num;
      q_in[0] = T_W'(ge);
      for (int k = 1; k < T_W; k++) begin
         r2      = {r_ff[k-1], 1'b0};
         ge      = r2 >= {1'b0, item_ff[k-1].den};
         r_in[k] = ge ? DIFF_W'(r2 - {1'b0, item_ff[k-1].den}) : DIFF_W'(r2);
         q_in[k] = {q_ff[k-1][T_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < T_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < T_W; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= in_item;
      for (int k = 1; k < T_W; k++) begin
         item_ff[k] <= item_ff[k-1];
      end
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign out_valid = v_ff[T_W-1];
   assign out_t     = q_ff[T_W-1];
   assign out_item  = item_ff[T_W-1];

endmodule

`default_nettype wire

// ===== rtl/ssc_back.sv =====
// ----------------------------------------------------------------------------
// ssc_back: crossing evaluation
// Divides for t, interpolates local x at the crossing, and forms the hit,
// distance-valid and distance result.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ssc_pkg::ssc_cfg_type    cfg,
   input  logic                    in_valid,
   input  ssc_pkg::ssc_item_type   in_item,
   output logic                    out_strobe,
   output ssc_pkg::ssc_result_type out_result
);
   import ssc_pkg::*;

   logic                    div_valid;
   logic [T_W-1:0]          div_t;
   ssc_item_type            div_item;

   logic                    m1_v_ff, m2_v_ff, out_v_ff;
   logic signed [MP_W-1:0]  m1_prod_ff, m1_prod_in;
   ssc_item_type            m1_item_ff, m2_item_ff;
   logic signed [XC_W-1:0]  m2_xc_ff, m2_xc_in;
   ssc_result_type          res_ff, res_in;

   ssc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .out_valid (div_valid),
      .out_t     (div_t),
      .out_item  (div_item)
   );

   always_comb begin
      logic signed [MP_W-1:0] xsum;
      logic signed [XC_W-1:0] axc;
      logic signed [T_W:0]    ts;
      ts         = signed'({1'b0, div_t});
      m1_prod_in = ts * signed'(div_item.dx);
      xsum       = MP_W'(signed'(m1_item_ff.xb)) + (m1_prod_ff >>> COORD_FRAC_BITS);
      m2_xc_in   = XC_W'(xsum);
      axc        = m2_xc_ff[XC_W-1] ? -m2_xc_ff : m2_xc_ff;
      res_in.hit = m2_item_ff.in_range && (unsigned'(axc) <= XC_W'(cfg.half_width));
      res_in.dist_valid = !res_in.hit && m2_item_ff.beg_inside;
      res_in.distance   = res_in.dist_valid ? m2_item_ff.zb : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         m1_v_ff  <= div_valid;
         m2_v_ff  <= m1_v_ff;
         out_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_prod_ff <= m1_prod_in;
      m1_item_ff <= div_item;
      m2_xc_ff   <= m2_xc_in;
      m2_item_ff <= m1_item_ff;
      res_ff     <= res_in;
   end

   assign out_strobe = out_v_ff;
   assign out_result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks for segment_strip_crossing
// Watches result encoding and the fixed transaction latency at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic                               rsp_hit,
   input logic                               rsp_dist_valid,
   input logic signed [ssc_pkg::LOC_W-1:0]   rsp_distance
);
   import ssc_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // pipeline is flushed by reset
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_hit_no_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> !rsp_dist_valid)
      else $error("hit reported with a valid distance");

   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_dist_valid |-> rsp_distance == '0)
      else $error("distance not zero while invalid");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, RSP_LATENCY))
      else $error("result without a matching transaction");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LATENCY rsp_strobe)
      else $error("transaction produced no result");

endmodule

bind segment_strip_crossing ssc_checker u_ssc_checker (.*);

`default_nettype wire

// ===== bench/segment_strip_crossing_tb.sv =====
// ----------------------------------------------------------------------------
// segment_strip_crossing_tb: self-checking bench for the strip crossing block
// Segments are fed through start/busy from a queue. The bench maps both end
// points into the strip frame itself, works out hit / distance for every
// accepted transaction and checks each strobed result in order. The register
// set is rewritten between phases while the block is idle, covering reset,
// extreme and random transforms.
// ----------------------------------------------------------------------------
module segment_strip_crossing_tb;
   import ssc_pkg::*;

   localparam int                 PHASES      = 10;
   localparam int                 PHASE_ITEMS = 194;
   localparam int                 STALL_LIMIT = 4000;
   localparam int                 MAX_PRINTS  = 100;
   localparam logic signed [31:0] ONE         = 32'sd65536;
   localparam int                 STYLES [PHASES] = '{0, 1, 2, 4, 3, 2, 4, 2, 3, 5};

   typedef struct {
      logic signed [COORD_W-1:0] bx, by, bz, ex, ey, ez;
      int unsigned               gap;
      bit                        drain;
   } segment_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_beg_x = '0;
   logic signed [COORD_W-1:0] req_beg_y = '0;
   logic signed [COORD_W-1:0] req_beg_z = '0;
   logic signed [COORD_W-1:0] req_end_x = '0;
   logic signed [COORD_W-1:0] req_end_y = '0;
   logic signed [COORD_W-1:0] req_end_z = '0;
   logic                      rsp_strobe;
   logic                      rsp_hit;
   logic                      rsp_dist_valid;
   logic signed [LOC_W-1:0]   rsp_distance;

   segment_type    segment_q[$];
   ssc_result_type verdict_q[$];
   segment_type    cur_seg;
   ssc_cfg_type    strip_cfg;
   int unsigned    hold_cnt = 0;
   int unsigned    stall_cycles = 0;
   int             n_queued = 0;
   int             n_accepted = 0;
   int             n_results = 0;
   int             n_hits = 0;
   int             n_dists = 0;
   int             n_errors = 0;

   segment_strip_crossing i_dut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .start          (start),
      .busy           (busy),
      .req_beg_x      (req_beg_x),
      .req_beg_y      (req_beg_y),
      .req_beg_z      (req_beg_z),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_end_z      (req_end_z),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_dist_valid (rsp_dist_valid),
      .rsp_distance   (rsp_distance)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one row of the affine inverse: floor of the Q2.14 sum, offset, saturate
   function automatic longint to_strip_frame(logic [ROW_W-1:0] coefs, logic [OFS_W-1:0] ofs,
                                             longint px, longint py, longint pz);
      longint acc;
      acc = longint'($signed(coefs[15:0])) * px + longint'($signed(coefs[31:16])) * py
          + longint'($signed(coefs[47:32])) * pz;
      acc = (acc >>> COEF_FRAC_BITS) + longint'($signed(ofs));
      if (acc > longint'(LOC_MAX)) acc = longint'(LOC_MAX);
      else if (acc < longint'(LOC_MIN)) acc = longint'(LOC_MIN);
      return acc;
   endfunction

   function automatic ssc_result_type crossing_verdict(segment_type s, ssc_cfg_type c);
      ssc_result_type r;
      longint xb, zb, xe, ze, num, den, t, xc, hw;
      hw = longint'(c.half_width);
      xb = to_strip_frame(c.x_row_coefs, c.x_row_offset, s.bx, s.by, s.bz);
      zb = to_strip_frame(c.z_row_coefs, c.z_row_offset, s.bx, s.by, s.bz);
      xe = to_strip_frame(c.x_row_coefs, c.x_row_offset, s.ex, s.ey, s.ez);
      ze = to_strip_frame(c.z_row_coefs, c.z_row_offset, s.ex, s.ey, s.ez);
      r = '0;
      den = ze - zb;
      num = -zb;
      if (den != 0) begin
         if (den < 0) begin
            den = -den;
            num = -num;
         end
         if (num >= 0 && num <= den) begin
            t  = (num <<< COORD_FRAC_BITS) / den;
            xc = xb + ((t * (xe - xb)) >>> COORD_FRAC_BITS);
            if ((xc < 0 ? -xc : xc) <= hw) r.hit = 1'b1;
         end
      end
      if (!r.hit && (xb < 0 ? -xb : xb) < hw) begin
         r.dist_valid = 1'b1;
         r.distance   = zb[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      n_errors++;
      if (n_errors <= MAX_PRINTS)
         $display("%0t: transaction %0d: %s got %0d, want %0d", $time, n_results, what, got, want);
   endtask

   // driver: a new segment goes out once its gap has elapsed and, if it drains, once no result is outstanding
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         hold_cnt <= 0;
      end else begin
         if (start && !busy) begin
            verdict_q.push_back(crossing_verdict(cur_seg, strip_cfg));
            n_accepted++;
         end
         if (!start || !busy) begin
            if (segment_q.size() == 0) begin
               start <= 1'b0;
            end else if (hold_cnt < segment_q[0].gap ||
                         (segment_q[0].drain && verdict_q.size() != 0)) begin
               start    <= 1'b0;
               hold_cnt <= hold_cnt + 1;
            end else begin
               cur_seg = segment_q.pop_front();
               req_beg_x <= cur_seg.bx;
               req_beg_y <= cur_seg.by;
               req_beg_z <= cur_seg.bz;
               req_end_x <= cur_seg.ex;
               req_end_y <= cur_seg.ey;
               req_end_z <= cur_seg.ez;
               start     <= 1'b1;
               hold_cnt  <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ssc_result_type want;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (verdict_q.size() == 0) begin
            report_mismatch("result with nothing outstanding, hit", rsp_hit, 0);
         end else begin
            want = verdict_q.pop_front();
            if (want.hit) n_hits++;
            if (want.dist_valid) n_dists++;
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_dist_valid !== want.dist_valid)
               report_mismatch("dist_valid", rsp_dist_valid, want.dist_valid);
            if (rsp_distance !== want.distance)
               report_mismatch("distance", rsp_distance, want.distance);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pwrite)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("segment_strip_crossing_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic signed [31:0] rand_coord(int unsigned bits);
      return $signed($urandom) >>> (31 - bits);
   endfunction

   function automatic segment_type mk_seg(logic signed [31:0] bx, by, bz, ex, ey, ez);
      segment_type s;
      s.bx = bx; s.by = by; s.bz = bz;
      s.ex = ex; s.ey = ey; s.ez = ez;
      s.gap = 0;
      s.drain = 0;
      return s;
   endfunction

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return LOC_MAX;
         1: return LOC_MIN;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic segment_type random_segment();
      segment_type       s;
      int unsigned       sc;
      logic signed [31:0] tmp;
      sc = $urandom_range(8, 24);
      s = mk_seg(rand_coord(sc), rand_coord(sc), 0, rand_coord(sc), rand_coord(sc), 0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            // end points on both sides of the plane
            s.bz = $urandom_range(0, 1 << sc);
            s.ez = -int'($urandom_range(0, 1 << sc));
            if ($urandom_range(0, 1)) begin
               tmp = s.bz; s.bz = s.ez; s.ez = tmp;
            end
         end
         6: s = mk_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         7: begin
            // parallel to the plane or a single point
            s.bz = rand_coord(sc);
            s.ez = s.bz;
            if ($urandom_range(0, 1)) begin
               s.ex = s.bx; s.ey = s.by;
            end
         end
         8: s = mk_seg(pick_extreme(), pick_extreme(), pick_extreme(),
                       pick_extreme(), pick_extreme(), pick_extreme());
         default: begin
            // one end point on the plane
            s.bz = rand_coord(sc);
            s.ez = 0;
            if ($urandom_range(0, 1)) begin
               s.ez = s.bz; s.bz = 0;
            end
         end
      endcase
      return s;
   endfunction

   function automatic ssc_cfg_type make_cfg(int style);
      ssc_cfg_type c;
      case (style)
         0: begin
            c.x_row_coefs  = {3{16'h7FFF}};
            c.x_row_offset = LOC_MAX;
            c.z_row_coefs  = {3{16'h7FFF}};
            c.z_row_offset = LOC_MAX;
            c.half_width   = '1;
         end
         1: begin
            c.x_row_coefs  = {3{16'h8000}};
            c.x_row_offset = LOC_MIN;
            c.z_row_coefs  = {3{16'h8000}};
            c.z_row_offset = LOC_MIN;
            c.half_width   = '0;
         end
         2: begin
            // close to the identity, small tilt
            c.x_row_coefs  = {16'(rand_coord(9)), 16'(rand_coord(9)),
                              16'(COEF_ONE + rand_coord(9))};
            c.z_row_coefs  = {16'(COEF_ONE + rand_coord(9)), 16'(rand_coord(9)),
                              16'(rand_coord(9))};
            c.x_row_offset = rand_coord(20);
            c.z_row_offset = rand_coord(20);
            c.half_width   = HW_W'($urandom_range(1 << 8, 1 << 22));
         end
         3: begin
            c.x_row_coefs  = ROW_W'({$urandom, $urandom});
            c.x_row_offset = $urandom;
            c.z_row_coefs  = ROW_W'({$urandom, $urandom});
            c.z_row_offset = $urandom;
            c.half_width   = HW_W'($urandom);
         end
         4: begin
            c.x_row_coefs  = {16'(rand_coord(14)), 16'(rand_coord(14)), 16'(rand_coord(14))};
            c.z_row_coefs  = {16'(rand_coord(14)), 16'(rand_coord(14)), 16'(rand_coord(14))};
            c.x_row_offset = rand_coord(24);
            c.z_row_offset = rand_coord(24);
            c.half_width   = HW_W'($urandom_range(0, 1 << 24));
         end
         default: begin
            c.x_row_coefs  = X_COEFS_RST;
            c.x_row_offset = '0;
            c.z_row_coefs  = Z_COEFS_RST;
            c.z_row_offset = '0;
            c.half_width   = HW_RST;
         end
      endcase
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {CSR_IDX_LSB{1'b0}}};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_X_COEFS:    strip_cfg.x_row_coefs  = value[ROW_W-1:0];
         REG_X_OFFSET:   strip_cfg.x_row_offset = value[OFS_W-1:0];
         REG_Z_COEFS:    strip_cfg.z_row_coefs  = value[ROW_W-1:0];
         REG_Z_OFFSET:   strip_cfg.z_row_offset = value[OFS_W-1:0];
         REG_HALF_WIDTH: strip_cfg.half_width   = value[HW_W-1:0];
         default: ;
      endcase
   endtask

   // wait until every segment is in and every result is out
   task automatic wait_idle();
      do @(negedge clock);
      while (n_accepted != n_queued || verdict_q.size() != 0);
      repeat (RSP_LATENCY + 5) @(negedge clock);
   endtask

   initial begin
      segment_type s;
      ssc_cfg_type c;
      strip_cfg = make_cfg(5);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hand-picked segments against the reset transform, unit half width
      segment_q.push_back(mk_seg(0, 0, -ONE, 0, 0, ONE));
      segment_q.push_back(mk_seg(ONE, 0, -ONE, ONE, 0, ONE));
      segment_q.push_back(mk_seg(ONE + 1, 0, -ONE, ONE + 1, 0, ONE));
      segment_q.push_back(mk_seg(-ONE / 2, 0, 3 * ONE, ONE / 2, 0, 3 * ONE));
      segment_q.push_back(mk_seg(0, 0, 0, 5 * ONE, 0, ONE));
      segment_q.push_back(mk_seg(3 * ONE, 0, -ONE, 0, 0, 0));
      segment_q.push_back(mk_seg(ONE / 4, 0, 2 * ONE, ONE / 4, 0, 5 * ONE));
      segment_q.push_back(mk_seg(ONE, 0, 2 * ONE, ONE, 0, 5 * ONE));
      segment_q.push_back(mk_seg(-ONE, 0, -2 * ONE, -ONE / 2, 0, -ONE));
      s = mk_seg(0, 0, ONE, 0, 0, -ONE);
      s.drain = 1;
      segment_q.push_back(s);
      segment_q.push_back(mk_seg(LOC_MAX, LOC_MAX, LOC_MAX, LOC_MAX, LOC_MAX, LOC_MAX));
      segment_q.push_back(mk_seg(LOC_MIN, LOC_MIN, LOC_MIN, LOC_MIN, LOC_MIN, LOC_MIN));
      segment_q.push_back(mk_seg(LOC_MIN, LOC_MAX, LOC_MIN, LOC_MAX, LOC_MIN, LOC_MAX));
      segment_q.push_back(mk_seg(-1, -1, -1, 1, 1, 1));
      segment_q.push_back(mk_seg(0, 0, 0, 0, 0, 0));
      segment_q.push_back(mk_seg(4 * ONE, 0, -ONE, -4 * ONE, 0, ONE));
      segment_q.push_back(mk_seg(LOC_MAX, 0, -ONE, LOC_MIN, 0, ONE));
      segment_q.push_back(mk_seg(0, LOC_MAX, -ONE, 0, LOC_MIN, ONE));
      n_queued = segment_q.size();

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         c = make_cfg(STYLES[p]);
         // junk above each register's width must be dropped
         write_reg(REG_X_COEFS,    {16'($urandom), c.x_row_coefs});
         write_reg(REG_X_OFFSET,   {$urandom, c.x_row_offset});
         write_reg(REG_Z_COEFS,    {16'($urandom), c.z_row_coefs});
         write_reg(REG_Z_OFFSET,   {$urandom, c.z_row_offset});
         write_reg(REG_HALF_WIDTH, {$urandom, 1'($urandom), c.half_width});
         @(negedge clock);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            s = random_segment();
            case (p % 3)
               0: s.gap = 0;
               1: s.gap = $urandom_range(0, 16);
               default: s.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
            endcase
            s.drain = ($urandom_range(0, 99) == 0);
            segment_q.push_back(s);
         end
         n_queued += PHASE_ITEMS;
      end

      wait_idle();
      $display("segments %0d, results %0d, over %0d register settings", n_accepted, n_results,
               PHASES + 1);
      $display("crossings seen %0d, valid distances %0d, mismatches %0d", n_hits, n_dists,
               n_errors);
      if (n_errors == 0) begin
         $display("segment_strip_crossing_tb: done, clean");
      end else begin
         $display("segment_strip_crossing_tb: done, errors");
      end
      $finish;
   end

endmodule
